// File: hw/rtl/rse_pkg.sv
// Shared types, codes and defaults for the RPN stack evaluator.
package rse_pkg;

    localparam int STACK_DEPTH_DEF   = 128;
    localparam int VALUE_WIDTH_DEF   = 48;
    localparam int FRACTION_BITS_DEF = 16;

    localparam int MODE_W   = 2;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 3;
    localparam int DEPTH_W  = 8;

    // Item modes
    localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OPER = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

    // Operator codes
    localparam logic [OP_W-1:0] OP_ADD = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB = 2'd1;
    localparam logic [OP_W-1:0] OP_MUL = 2'd2;
    localparam logic [OP_W-1:0] OP_DIV = 2'd3;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FEW       = 3'd2;
    localparam logic [STATUS_W-1:0] ST_DIVZERO   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd4;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP
    } t_cell_cmd;

    typedef enum logic [1:0] {
        STK_HOLD,
        STK_PUSH,
        STK_REPLACE
    } t_stack_op;

    typedef enum logic [1:0] {
        S_IDLE,
        S_ALU,
        S_DONE
    } t_state;

    typedef enum logic [2:0] {
        A_IDLE,
        A_ADD,
        A_MUL,
        A_DIV,
        A_SAT,
        A_FIN
    } t_alu_state;

    typedef struct packed {
        logic            start;
        logic [OP_W-1:0] op;
    } t_alu_req;

endpackage

// File: hw/rtl/rse_cell.sv
// One stack cell: holds an entry, loads from the cell above or below.
module rse_cell #(
    parameter int VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  rse_pkg::t_cell_cmd     i_cmd,
    input  logic [VALUE_WIDTH-1:0] i_from_up,
    input  logic [VALUE_WIDTH-1:0] i_from_down,
    output logic [VALUE_WIDTH-1:0] o_value
);

    logic [VALUE_WIDTH-1:0] r_value;

    always_ff @(posedge i_clk) begin
        case (i_cmd)
            rse_pkg::CELL_PUSH: r_value <= i_from_up;
            rse_pkg::CELL_POP:  r_value <= i_from_down;
            default:            r_value <= r_value;
        endcase
    end

    assign o_value = r_value;

endmodule

// File: hw/rtl/rse_stack.sv
// Operand stack built as a shifting chain of cells; cell 0 is the top.
module rse_stack #(
    parameter int STACK_DEPTH = rse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH = rse_pkg::VALUE_WIDTH_DEF
) (
    input  logic                   i_clk,
    input  rse_pkg::t_stack_op     i_op,
    input  logic [VALUE_WIDTH-1:0] i_value,
    output logic [VALUE_WIDTH-1:0] o_top,
    output logic [VALUE_WIDTH-1:0] o_next
);

    logic [VALUE_WIDTH-1:0] w_val [STACK_DEPTH];

    for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0] w_up;
        logic [VALUE_WIDTH-1:0] w_down;
        rse_pkg::t_cell_cmd     w_cmd;

        if (g == 0) begin : g_head
            assign w_up  = i_value;
            // replace loads the new top, push shifts it in
            assign w_cmd = (i_op == rse_pkg::STK_HOLD) ? rse_pkg::CELL_HOLD
                                                       : rse_pkg::CELL_PUSH;
        end else begin : g_body
            assign w_up  = w_val[g-1];
            assign w_cmd = (i_op == rse_pkg::STK_PUSH)    ? rse_pkg::CELL_PUSH :
                           (i_op == rse_pkg::STK_REPLACE) ? rse_pkg::CELL_POP  :
                                                            rse_pkg::CELL_HOLD;
        end

        if (g == STACK_DEPTH - 1) begin : g_tail
            assign w_down = '0;
        end else begin : g_mid
            assign w_down = w_val[g+1];
        end

        rse_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_from_up   (w_up),
            .i_from_down (w_down),
            .o_value     (w_val[g])
        );
    end

    assign o_top  = w_val[0];
    assign o_next = w_val[1];

endmodule

// File: hw/rtl/rse_alu.sv
// Sign-magnitude fixed-point ALU: add/sub, shift-add multiply, restoring divide.
module rse_alu #(
    parameter int VALUE_WIDTH   = rse_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = rse_pkg::FRACTION_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  rse_pkg::t_alu_req      i_req,
    input  logic [VALUE_WIDTH-1:0] i_a,
    input  logic [VALUE_WIDTH-1:0] i_b,
    output logic                   o_done,
    output logic [VALUE_WIDTH-1:0] o_result
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRACTION_BITS;
    localparam int QW   = W + F;          // quotient bits
    localparam int XW   = 2 * W + F;      // wide magnitude
    localparam int CNTW = $clog2(QW + 1);
    localparam logic [XW-1:0] LIMIT = XW'(1) << (W - 1);

    // saturate a sign and wide magnitude into a W-bit pattern
    function automatic logic [W-1:0] sat(input logic neg, input logic [XW-1:0] mag);
        logic [W-1:0] res;
        if (neg) begin
            res = (mag > LIMIT) ? {1'b1, {(W-1){1'b0}}} : W'(~mag + XW'(1));
        end else begin
            res = (mag > LIMIT - XW'(1)) ? {1'b0, {(W-1){1'b1}}} : mag[W-1:0];
        end
        return res;
    endfunction

    rse_pkg::t_alu_state r_state, n_state;

    logic            r_na, n_na, r_nb, n_nb;
    logic [W-1:0]    r_ma, n_ma, r_mb, n_mb;
    logic [1:0]      r_op, n_op;
    logic [XW-1:0]   r_acc, n_acc;
    logic [W:0]      r_rem, n_rem;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic [W-1:0]    r_result, n_result;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rse_pkg::A_IDLE: begin
                if (i_req.start) begin
                    case (i_req.op)
                        rse_pkg::OP_MUL: n_state = rse_pkg::A_MUL;
                        rse_pkg::OP_DIV: n_state = rse_pkg::A_DIV;
                        default:         n_state = rse_pkg::A_ADD;
                    endcase
                end
            end
            rse_pkg::A_ADD: n_state = rse_pkg::A_FIN;
            rse_pkg::A_MUL, rse_pkg::A_DIV: begin
                if (r_cnt == CNTW'(1)) n_state = rse_pkg::A_SAT;
            end
            rse_pkg::A_SAT: n_state = rse_pkg::A_FIN;
            rse_pkg::A_FIN: n_state = rse_pkg::A_IDLE;
            default:        n_state = rse_pkg::A_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        logic [W:0]    sum;
        logic          sgn;
        logic [W:0]    rem_sh;
        logic          ge;
        logic [XW-1:0] wide;

        n_na     = r_na;
        n_nb     = r_nb;
        n_ma     = r_ma;
        n_mb     = r_mb;
        n_op     = r_op;
        n_acc    = r_acc;
        n_rem    = r_rem;
        n_cnt    = r_cnt;
        n_result = r_result;
        sum      = '0;
        sgn      = 1'b0;
        rem_sh   = {r_rem[W-1:0], r_acc[QW-1]};
        ge       = rem_sh >= {1'b0, r_mb};
        wide     = '0;

        case (r_state)
            rse_pkg::A_IDLE: begin
                if (i_req.start) begin
                    n_op  = i_req.op;
                    n_na  = i_a[W-1];
                    n_ma  = i_a[W-1] ? (~i_a + W'(1)) : i_a;
                    n_mb  = i_b[W-1] ? (~i_b + W'(1)) : i_b;
                    // subtract flips the sign of a nonzero b
                    n_nb  = (i_req.op == rse_pkg::OP_SUB) ? ((|i_b) & ~i_b[W-1])
                                                          : i_b[W-1];
                    n_rem = '0;
                    if (i_req.op == rse_pkg::OP_DIV) begin
                        n_acc = XW'(n_ma) << F;
                        n_cnt = CNTW'(QW);
                    end else begin
                        n_acc = '0;
                        n_cnt = CNTW'(W);
                    end
                end
            end
            rse_pkg::A_ADD: begin
                if (r_na == r_nb) begin
                    sum = {1'b0, r_ma} + {1'b0, r_mb};
                    sgn = r_na;
                end else if (r_ma >= r_mb) begin
                    sum = {1'b0, r_ma - r_mb};
                    sgn = r_na;
                end else begin
                    sum = {1'b0, r_mb - r_ma};
                    sgn = r_nb;
                end
                n_result = sat(sgn, XW'(sum));
            end
            rse_pkg::A_MUL: begin
                n_acc = (r_acc << 1) + (r_mb[W-1] ? XW'(r_ma) : '0);
                n_mb  = r_mb << 1;
                n_cnt = r_cnt - CNTW'(1);
            end
            rse_pkg::A_DIV: begin
                n_rem = ge ? (rem_sh - {1'b0, r_mb}) : rem_sh;
                n_acc = {r_acc[XW-2:0], ge};
                n_cnt = r_cnt - CNTW'(1);
            end
            rse_pkg::A_SAT: begin
                wide     = (r_op == rse_pkg::OP_MUL) ? (r_acc >> F) : XW'(r_acc[QW-1:0]);
                n_result = sat(r_na ^ r_nb, wide);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rse_pkg::A_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_na     <= n_na;
        r_nb     <= n_nb;
        r_ma     <= n_ma;
        r_mb     <= n_mb;
        r_op     <= n_op;
        r_acc    <= n_acc;
        r_rem    <= n_rem;
        r_cnt    <= n_cnt;
        r_result <= n_result;
    end

    assign o_done   = (r_state == rse_pkg::A_FIN);
    assign o_result = r_result;

endmodule

// File: hw/rtl/rpn_stack_evaluator.sv
// Top level of the RPN stack evaluator: control, error latch and result register.
//
//  channel   direction  handshake                 payload
//  -------   ---------  ------------------------  ---------------------------------------
//  input     in         i_in_valid / o_in_ready   i_mode, i_number_value, i_operator_code
//  result    out        o_out_valid / i_out_ready o_status, o_top_value, o_stack_depth,
//                                                 o_expression_done
//
//  One item at a time. The result register loads from state S_DONE once it is free. Push, end,
//  error and ignored items go there straight from the input transfer; add and subtract pass
//  ALU states ADD and FIN first, multiply MUL (one bit per cycle), SAT and FIN, and divide DIV
//  (restoring, one quotient bit per cycle), SAT and FIN. Input is taken again after that load.
//  Reset clears the depth count, the error latch and both state machines; stack cells
//  are not cleared. A stalled result waits in the output register while the next item
//  is taken; that item's result then waits until the register drains.
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH   = rse_pkg::STACK_DEPTH_DEF,
    parameter int VALUE_WIDTH   = rse_pkg::VALUE_WIDTH_DEF,
    parameter int FRACTION_BITS = rse_pkg::FRACTION_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [rse_pkg::MODE_W-1:0]          i_mode,
    input  logic signed [VALUE_WIDTH-1:0]       i_number_value,
    input  logic [rse_pkg::OP_W-1:0]            i_operator_code,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [rse_pkg::STATUS_W-1:0]        o_status,
    output logic signed [VALUE_WIDTH-1:0]       o_top_value,
    output logic [rse_pkg::DEPTH_W-1:0]         o_stack_depth,
    output logic                                o_expression_done
);

    localparam int CW = $clog2(STACK_DEPTH + 1);

    rse_pkg::t_state r_state, n_state;

    logic [CW-1:0]                  r_count, n_count;
    logic [rse_pkg::STATUS_W-1:0]   r_err, n_err;
    // end-of-expression result, captured before the depth count is cleared
    logic                           r_is_end, n_is_end;
    logic [rse_pkg::STATUS_W-1:0]   r_end_status, n_end_status;
    logic [VALUE_WIDTH-1:0]         r_end_top, n_end_top;

    // output register
    logic                           r_o_valid;
    logic [rse_pkg::STATUS_W-1:0]   r_o_status;
    logic [VALUE_WIDTH-1:0]         r_o_top;
    logic [rse_pkg::DEPTH_W-1:0]    r_o_depth;
    logic                           r_o_done;

    logic                   w_in_xfer;
    logic                   w_out_free;
    logic                   w_out_load;
    logic                   w_op_ok;
    rse_pkg::t_stack_op     w_stk_op;
    logic [VALUE_WIDTH-1:0] w_stk_value;
    logic [VALUE_WIDTH-1:0] w_top;
    logic [VALUE_WIDTH-1:0] w_next;
    rse_pkg::t_alu_req      w_alu_req;
    logic                   w_alu_done;
    logic [VALUE_WIDTH-1:0] w_alu_result;

    assign o_in_ready = (r_state == rse_pkg::S_IDLE);
    assign w_in_xfer  = i_in_valid && o_in_ready;
    assign w_out_free = !r_o_valid || i_out_ready;
    assign w_out_load = (r_state == rse_pkg::S_DONE) && w_out_free;

    // operator item that really goes to the ALU
    assign w_op_ok = (i_mode == rse_pkg::MODE_OPER) && (r_err == rse_pkg::ST_OK) &&
                     (r_count >= CW'(2)) &&
                     !((i_operator_code == rse_pkg::OP_DIV) && (w_top == '0));

    rse_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_op    (w_stk_op),
        .i_value (w_stk_value),
        .o_top   (w_top),
        .o_next  (w_next)
    );

    rse_alu #(
        .VALUE_WIDTH   (VALUE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_req    (w_alu_req),
        .i_a      (w_next),
        .i_b      (w_top),
        .o_done   (w_alu_done),
        .o_result (w_alu_result)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            rse_pkg::S_IDLE: begin
                if (w_in_xfer) n_state = w_op_ok ? rse_pkg::S_ALU : rse_pkg::S_DONE;
            end
            rse_pkg::S_ALU: begin
                if (w_alu_done) n_state = rse_pkg::S_DONE;
            end
            rse_pkg::S_DONE: begin
                if (w_out_free) n_state = rse_pkg::S_IDLE;
            end
            default: n_state = rse_pkg::S_IDLE;
        endcase
    end

    // stack, error latch and ALU control
    always_comb begin
        n_count         = r_count;
        n_err           = r_err;
        n_is_end        = r_is_end;
        n_end_status    = r_end_status;
        n_end_top       = r_end_top;
        w_stk_op        = rse_pkg::STK_HOLD;
        w_stk_value     = VALUE_WIDTH'(i_number_value);
        w_alu_req.start = 1'b0;
        w_alu_req.op    = i_operator_code;

        case (r_state)
            rse_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    n_is_end = 1'b0;
                    case (i_mode)
                        rse_pkg::MODE_PUSH: begin
                            if (r_err == rse_pkg::ST_OK) begin
                                if (r_count >= CW'(STACK_DEPTH)) begin
                                    n_err = rse_pkg::ST_FULL;
                                end else begin
                                    w_stk_op = rse_pkg::STK_PUSH;
                                    n_count  = r_count + CW'(1);
                                end
                            end
                        end
                        rse_pkg::MODE_OPER: begin
                            if (r_err == rse_pkg::ST_OK) begin
                                if (r_count < CW'(2)) begin
                                    n_err = rse_pkg::ST_FEW;
                                end else if (w_op_ok) begin
                                    w_alu_req.start = 1'b1;
                                end else begin
                                    n_err = rse_pkg::ST_DIVZERO;
                                end
                            end
                        end
                        rse_pkg::MODE_END: begin
                            n_is_end  = 1'b1;
                            n_end_top = '0;
                            if (r_err != rse_pkg::ST_OK) begin
                                n_end_status = r_err;
                            end else if (r_count != CW'(1)) begin
                                n_end_status = rse_pkg::ST_MALFORMED;
                            end else begin
                                n_end_status = rse_pkg::ST_OK;
                                n_end_top    = w_top;
                            end
                            n_count = '0;
                            n_err   = rse_pkg::ST_OK;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rse_pkg::S_ALU: begin
                if (w_alu_done) begin
                    // pop two, push result: top takes the result, the rest shift up
                    w_stk_op    = rse_pkg::STK_REPLACE;
                    w_stk_value = w_alu_result;
                    n_count     = r_count - CW'(1);
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rse_pkg::S_IDLE;
            r_count   <= '0;
            r_err     <= rse_pkg::ST_OK;
            r_is_end  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_err    <= n_err;
            r_is_end <= n_is_end;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_end_status <= n_end_status;
        r_end_top    <= n_end_top;
        if (w_out_load) begin
            if (r_is_end) begin
                r_o_status <= r_end_status;
                r_o_top    <= r_end_top;
                r_o_done   <= 1'b1;
            end else begin
                r_o_status <= r_err;
                r_o_top    <= (r_count != '0) ? w_top : '0;
                r_o_done   <= 1'b0;
            end
            r_o_depth <= rse_pkg::DEPTH_W'(r_count);
        end
    end

    assign o_out_valid       = r_o_valid;
    assign o_status          = r_o_status;
    assign o_top_value       = r_o_top;
    assign o_stack_depth     = r_o_depth;
    assign o_expression_done = r_o_done;

endmodule
